[hdl/vaps_pkg.sv]
// ----------------------------------------------------------------------------
// vaps_pkg
// Shared constants, state encoding and types for the 3-D point smoother.
// ----------------------------------------------------------------------------
package vaps_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_WIDTH       = 32;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int WEIGHT_WIDTH    = 17;
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = 17'h10000;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_CUTOFF  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_SCALE = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_GAIN  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_KEEP  = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DEPTH       = 3'd4;

  localparam logic [31:0] MIN_CUTOFF_RST  = 32'd7282;
  localparam logic [31:0] SPEED_SCALE_RST = 32'd65536;
  localparam logic [16:0] SPEED_GAIN_RST  = 17'd32768;
  localparam logic [16:0] SPEED_KEEP_RST  = 17'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL_A,    // speed_gain * delta
    ST_VEL_B,    // speed_keep * speed
    ST_VEL_FIN,
    ST_NORM,
    ST_SCALE,    // speed_scale * norm
    ST_CUT,
    ST_DIV,
    ST_MIX_A,    // alpha * in
    ST_MIX_B,    // (1-alpha) * smooth
    ST_MIX_FIN,
    ST_OUT
  } state_t;

  // Control between sequencer and serial multiplier
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctrl_t;

endpackage

[hdl/vaps_if.sv]
// ----------------------------------------------------------------------------
// vaps_if
// Valid/ready channel carrying one 3-D point and a function bit.
// ----------------------------------------------------------------------------
interface vaps_if #(
  parameter int COORD_WIDTH = vaps_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [COORD_WIDTH-1:0] x;
  logic signed [COORD_WIDTH-1:0] y;
  logic signed [COORD_WIDTH-1:0] z;

  modport source (output valid, func, x, y, z, input ready);
  modport sink   (input valid, func, x, y, z, output ready);
endinterface

[hdl/velocity_adaptive_point_smoother_3d_top.sv]
// ----------------------------------------------------------------------------
// velocity_adaptive_point_smoother_3d_top
// Velocity-adaptive exponential smoother for one 3-D point per request.
// ----------------------------------------------------------------------------
// One request at a time: a new request is taken only once the previous result
// has been taken. A load request goes from ST_IDLE to ST_OUT and gives its
// result from there. A filter request runs on the shared bit-serial multiplier
// and divider: 13 products (gain and keep terms of the velocity and the two
// blend terms on each axis, plus the speed scale), the alpha division, the
// norm, and a closing step per axis for each velocity and blend sum.
module velocity_adaptive_point_smoother_3d_top #(
  parameter int COORD_WIDTH = vaps_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vaps_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [vaps_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [vaps_pkg::CFG_WIDTH-1:0]        cfg_data,
  vaps_if.sink                                  in_ch,
  vaps_if.source                                out_ch
);
  localparam int CW  = COORD_WIDTH;
  localparam int AW  = CW + 2;          // multiplicand width
  localparam int PW  = AW + 32;         // product width
  localparam int NW  = CW + 2;          // L1 norm width
  localparam int WW  = vaps_pkg::WEIGHT_WIDTH;
  localparam logic signed [CW+1:0] CMAX = (CW+2)'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [CW+1:0] CMIN = -CMAX - 1;

  // configuration
  logic [31:0]   min_cutoff;
  logic [31:0]   speed_scale;
  logic [WW-1:0] speed_gain;
  logic [WW-1:0] speed_keep;
  logic          depth_in_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cutoff     <= vaps_pkg::MIN_CUTOFF_RST;
      speed_scale    <= vaps_pkg::SPEED_SCALE_RST;
      speed_gain     <= vaps_pkg::SPEED_GAIN_RST;
      speed_keep     <= vaps_pkg::SPEED_KEEP_RST;
      depth_in_speed <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vaps_pkg::REG_MIN_CUTOFF:  min_cutoff     <= cfg_data;
        vaps_pkg::REG_SPEED_SCALE: speed_scale    <= cfg_data;
        vaps_pkg::REG_SPEED_GAIN:  speed_gain     <= cfg_data[WW-1:0];
        vaps_pkg::REG_SPEED_KEEP:  speed_keep     <= cfg_data[WW-1:0];
        vaps_pkg::REG_DEPTH:       depth_in_speed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state
  logic signed [CW-1:0] smooth [3];
  logic signed [CW-1:0] speed  [3];
  logic signed [CW-1:0] pin    [3];
  logic                 func_r;
  logic [1:0]           axis;
  logic signed [PW-1:0] part;      // first product of a velocity or blend sum
  logic [NW-1:0]        norm;
  logic [33:0]          cval;
  logic [16:0]          alpha;
  logic signed [CW-1:0] res [3];
  logic                 out_valid;

  vaps_pkg::state_t state, state_next;

  // multiplier operands
  logic                 mul_start;
  logic signed [AW-1:0] mul_a;
  logic [31:0]          mul_b;
  logic                 mul_done;
  logic signed [PW-1:0] mul_p;
  vaps_pkg::mul_ctrl_t  mctl;

  logic                 div_start;
  logic                 div_done;
  logic [48:0]          div_q;
  logic [48:0]          div_num;
  logic [33:0]          div_den;

  // alpha = round(c * 2^16 / (2^16 + c))
  assign div_den = cval + 34'h10000;
  assign div_num = {cval[32:0], 16'h0} + 49'(div_den >> 1);

  vaps_mul #(.A_WIDTH(AW), .B_WIDTH(32)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  vaps_div #(.N_WIDTH(49), .D_WIDTH(34)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(div_den), .done(div_done), .quo(div_q)
  );

  logic [WW-1:0] g_cl, k_cl;
  assign g_cl = (speed_gain > vaps_pkg::WEIGHT_ONE) ? vaps_pkg::WEIGHT_ONE : speed_gain;
  assign k_cl = (speed_keep > vaps_pkg::WEIGHT_ONE) ? vaps_pkg::WEIGHT_ONE : speed_keep;

  // delta, saturated
  logic signed [CW:0]   delta_raw;
  logic signed [CW-1:0] delta;
  assign delta_raw = (CW+1)'(pin[axis]) - (CW+1)'(smooth[axis]);
  always_comb begin
    if (delta_raw > (CW+1)'(CMAX)) delta = CMAX[CW-1:0];
    else if (delta_raw < (CW+1)'(CMIN)) delta = CMIN[CW-1:0];
    else delta = delta_raw[CW-1:0];
  end

  // blend sum: floor parts + rounded low parts equals floor((p1+p2+0x8000)/2^16)
  logic signed [PW:0]   bsum;
  logic signed [PW-16:0] bq;
  logic signed [CW-1:0] bsat;
  assign bsum = (PW+1)'(part) + (PW+1)'(mul_p) + (PW+1)'(17'sh8000);
  assign bq   = bsum[PW:16];
  always_comb begin
    if (bq > (PW-15)'(CMAX)) bsat = CMAX[CW-1:0];
    else if (bq < (PW-15)'(CMIN)) bsat = CMIN[CW-1:0];
    else bsat = bq[CW-1:0];
  end

  // norm to Q16.16, saturated to 32 bits
  logic [NW+8:0] n16w;
  logic [31:0]   n16;
  assign n16w = (FRAC_BITS >= 16) ? (NW+9)'(norm >> (FRAC_BITS - 16))
                                  : (NW+9)'(norm) << (16 - FRAC_BITS);
  assign n16  = (n16w > (NW+9)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : n16w[31:0];

  logic [CW-1:0] mag_s;
  assign mag_s = speed[axis][CW-1] ? CW'(-speed[axis]) : speed[axis];

  logic [PW-1:0] prod_r;
  logic [32:0]   prod_s;
  logic [33:0]   csum;
  assign prod_r = PW'(mul_p) + PW'(32'h8000);
  assign prod_s = (prod_r[PW-1:16] > (PW-16)'(32'hFFFF_FFFF)) ? 33'h0FFFF_FFFF
                  : {1'b0, prod_r[47:16]};
  assign csum   = 34'(min_cutoff) + 34'(prod_s);

  always_comb begin
    state_next = state;
    unique case (state)
      vaps_pkg::ST_IDLE:    if (in_ch.valid && !out_valid)
                              state_next = in_ch.func ? vaps_pkg::ST_OUT : vaps_pkg::ST_VEL_A;
      vaps_pkg::ST_VEL_A:   if (mul_done) state_next = vaps_pkg::ST_VEL_B;
      vaps_pkg::ST_VEL_B:   if (mul_done) state_next = vaps_pkg::ST_VEL_FIN;
      vaps_pkg::ST_VEL_FIN: state_next = (axis == 2'd2) ? vaps_pkg::ST_NORM : vaps_pkg::ST_VEL_A;
      vaps_pkg::ST_NORM:    if (axis == 2'd2) state_next = vaps_pkg::ST_SCALE;
      vaps_pkg::ST_SCALE:   if (mul_done) state_next = vaps_pkg::ST_CUT;
      vaps_pkg::ST_CUT:     state_next = vaps_pkg::ST_DIV;
      vaps_pkg::ST_DIV:     if (div_done) state_next = vaps_pkg::ST_MIX_A;
      vaps_pkg::ST_MIX_A:   if (mul_done) state_next = vaps_pkg::ST_MIX_B;
      vaps_pkg::ST_MIX_B:   if (mul_done) state_next = vaps_pkg::ST_MIX_FIN;
      vaps_pkg::ST_MIX_FIN: state_next = (axis == 2'd2) ? vaps_pkg::ST_OUT : vaps_pkg::ST_MIX_A;
      vaps_pkg::ST_OUT:     state_next = vaps_pkg::ST_IDLE;
      default:              state_next = vaps_pkg::ST_IDLE;
    endcase
  end

  // multiplier control: start on entry to a multiply state
  logic entry;
  always_ff @(posedge clk) begin
    if (rst) entry <= 1'b0;
    else     entry <= (state_next != state) || (state == vaps_pkg::ST_IDLE);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      vaps_pkg::ST_VEL_A: begin mul_a = AW'(delta);        mul_b = 32'(g_cl); end
      vaps_pkg::ST_VEL_B: begin mul_a = AW'(speed[axis]);  mul_b = 32'(k_cl); end
      vaps_pkg::ST_SCALE: begin mul_a = AW'({2'b0, n16});  mul_b = speed_scale; end
      vaps_pkg::ST_MIX_A: begin mul_a = AW'(pin[axis]);    mul_b = 32'(alpha); end
      vaps_pkg::ST_MIX_B: begin mul_a = AW'(smooth[axis]);
                                mul_b = 32'(17'h10000 - alpha); end
      default: ;
    endcase
  end

  assign mctl.start = entry && !mctl.busy
                    && (state == vaps_pkg::ST_VEL_A || state == vaps_pkg::ST_VEL_B
                    || state == vaps_pkg::ST_SCALE || state == vaps_pkg::ST_MIX_A
                    || state == vaps_pkg::ST_MIX_B);
  assign mctl.busy  = 1'b0;
  assign mctl.done  = mul_done;
  assign mul_start  = mctl.start;
  assign div_start  = (state == vaps_pkg::ST_CUT);

  assign in_ch.ready = (state == vaps_pkg::ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vaps_pkg::ST_IDLE;
      out_valid <= 1'b0;
      axis      <= '0;
      for (int i = 0; i < 3; i++) begin
        smooth[i] <= '0;
        speed[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        vaps_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          pin[0] <= in_ch.x; pin[1] <= in_ch.y; pin[2] <= in_ch.z;
          func_r <= in_ch.func;
          axis   <= '0;
          norm   <= '0;
        end
        vaps_pkg::ST_VEL_A:   if (mul_done) part <= mul_p;
        vaps_pkg::ST_VEL_FIN: begin
          speed[axis] <= bsat;
          axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        vaps_pkg::ST_NORM: begin
          if (axis != 2'd2 || depth_in_speed) norm <= norm + NW'(mag_s);
          axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        // c saturates to 32 bits before the divider takes it
        vaps_pkg::ST_SCALE: if (mul_done)
          cval <= (csum > 34'h0FFFF_FFFF) ? 34'h0FFFF_FFFF : csum;
        vaps_pkg::ST_DIV: if (div_done)
          alpha <= (div_q > 49'h10000) ? 17'h10000 : div_q[16:0];
        vaps_pkg::ST_MIX_A: if (mul_done) part <= mul_p;
        vaps_pkg::ST_MIX_FIN: begin
          smooth[axis] <= bsat;
          axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        vaps_pkg::ST_OUT: begin
          if (func_r) begin
            for (int i = 0; i < 3; i++) begin
              smooth[i] <= pin[i];
              speed[i]  <= '0;
              res[i]    <= pin[i];
            end
          end else begin
            for (int i = 0; i < 3; i++) res[i] <= smooth[i];
          end
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.func  = func_r;
  assign out_ch.x     = res[0];
  assign out_ch.y     = res[1];
  assign out_ch.z     = res[2];
endmodule

[hdl/vaps_mul.sv]
// ----------------------------------------------------------------------------
// vaps_mul
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
// ----------------------------------------------------------------------------
module vaps_mul #(
  parameter int A_WIDTH = 34,
  parameter int B_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [A_WIDTH-1:0]         a,
  input  logic        [B_WIDTH-1:0]         b,
  output logic                              done,
  output logic signed [A_WIDTH+B_WIDTH-1:0] prod
);
  localparam int PW = A_WIDTH + B_WIDTH;
  localparam int CW = $clog2(B_WIDTH + 1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic [B_WIDTH-1:0]   mplier;
  logic [CW-1:0]        count;
  logic                 busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(B_WIDTH);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PW'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;
endmodule

[hdl/vaps_div.sv]
// ----------------------------------------------------------------------------
// vaps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vaps_div #(
  parameter int N_WIDTH = 49,
  parameter int D_WIDTH = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [N_WIDTH-1:0] num,
  input  logic [D_WIDTH-1:0] den,
  output logic               done,
  output logic [N_WIDTH-1:0] quo
);
  localparam int CW = $clog2(N_WIDTH + 1);

  logic [D_WIDTH:0]   rem;
  logic [D_WIDTH:0]   trial;
  logic [D_WIDTH-1:0] dvs;
  logic [N_WIDTH-1:0] q;
  logic [CW-1:0]      count;
  logic               busy;

  assign trial = {rem[D_WIDTH-1:0], q[N_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(N_WIDTH);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      dvs <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        q   <= {q[N_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[N_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quo = q;
endmodule
